### rtl/pcs_pkg.sv
`default_nettype none
package pcs_pkg;

  // Table size and field widths
  localparam int ENTRIES = 1024;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int IDX_W   = 10;
  localparam int POS_W   = 18;
  localparam int RAD_W   = 16;
  localparam int TYPE_W  = 16;
  localparam int SCAN_W  = 11;
  // Wide enough for a scan count, an index and ENTRIES itself
  localparam int CNT_W   = (ADDR_W + 1 > SCAN_W) ? ADDR_W + 1 : SCAN_W;

  // Flag word: alive, hit enable, type bits
  localparam int FLAG_W      = TYPE_W + 2;
  localparam int FLAG_ALIVE  = 0;
  localparam int FLAG_ENABLE = 1;
  localparam int FLAG_TYPE   = 2;

  // Entry data word: x, y, radius
  localparam int DATA_W = 2 * POS_W + RAD_W;

  localparam int DIST_W = POS_W;       // absolute axis delta
  localparam int RSUM_W = RAD_W + 1;   // summed radius

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic clear;     // zero the flag word at the sweep address, advance it
    logic write;     // store the incoming entry
    logic load;      // latch probe, start address, clear result
    logic issue;     // read the entry at the scan address, advance it
    logic flush;     // drop everything in the compare pipeline
    logic out_load;  // move the result into the output register
  } dp_cmd_t;

  typedef struct packed {
    logic addr_last;  // sweep address at last entry
    logic hit_found;  // compare pipeline reports a collision this cycle
    logic pipe_busy;  // compare pipeline holds entries
  } dp_status_t;

endpackage
`default_nettype wire

### rtl/pool_circle_collision_search_unit.sv
// Write transaction: after acceptance the controller goes straight to its finish state and
// loads the result there. A query with a clipped count of zero behaves the same.
// Query over n entries (scan count clipped at the table end): one entry read per cycle
// from the entry table into a 3-stage compare pipeline. The result holds the first hit in
// scan order; without a hit the pipeline drains before the result loads.
// Next transaction in the cycle after the result loads; a held result delays that load.
// After reset the flag table is swept to zero, one entry per cycle, over all ENTRIES (1024).
`default_nettype none
module pool_circle_collision_search_unit (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               in_cmd_i,
  input  wire logic        [pcs_pkg::IDX_W-1:0]    in_index_i,
  input  wire logic                               in_alive_i,
  input  wire logic        [pcs_pkg::TYPE_W-1:0]   in_type_bits_i,
  input  wire logic                               in_hit_enable_i,
  input  wire logic signed [pcs_pkg::POS_W-1:0]    in_pos_x_i,
  input  wire logic signed [pcs_pkg::POS_W-1:0]    in_pos_y_i,
  input  wire logic        [pcs_pkg::RAD_W-1:0]    in_radius_i,
  input  wire logic        [pcs_pkg::TYPE_W-1:0]   in_type_mask_i,
  input  wire logic        [pcs_pkg::IDX_W-1:0]    in_self_index_i,
  input  wire logic        [pcs_pkg::SCAN_W-1:0]   in_scan_count_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    out_hit_o,
  output logic             [pcs_pkg::IDX_W-1:0]    out_hit_index_o
);

  pcs_pkg::dp_cmd_t    dp_cmd;
  pcs_pkg::dp_status_t dp_status;

  pcs_controller u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_cmd_i        (in_cmd_i),
    .in_index_i      (in_index_i),
    .in_scan_count_i (in_scan_count_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .cmd_o           (dp_cmd),
    .status_i        (dp_status)
  );

  pcs_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .in_index_i      (in_index_i),
    .in_alive_i      (in_alive_i),
    .in_type_bits_i  (in_type_bits_i),
    .in_hit_enable_i (in_hit_enable_i),
    .in_pos_x_i      (in_pos_x_i),
    .in_pos_y_i      (in_pos_y_i),
    .in_radius_i     (in_radius_i),
    .in_type_mask_i  (in_type_mask_i),
    .in_self_index_i (in_self_index_i),
    .status_o        (dp_status),
    .out_hit_o       (out_hit_o),
    .out_hit_index_o (out_hit_index_o)
  );

endmodule
`default_nettype wire

### rtl/pcs_datapath.sv
`default_nettype none
module pcs_datapath (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire pcs_pkg::dp_cmd_t                 cmd_i,
  input  wire logic        [pcs_pkg::IDX_W-1:0]  in_index_i,
  input  wire logic                             in_alive_i,
  input  wire logic        [pcs_pkg::TYPE_W-1:0] in_type_bits_i,
  input  wire logic                             in_hit_enable_i,
  input  wire logic signed [pcs_pkg::POS_W-1:0]  in_pos_x_i,
  input  wire logic signed [pcs_pkg::POS_W-1:0]  in_pos_y_i,
  input  wire logic        [pcs_pkg::RAD_W-1:0]  in_radius_i,
  input  wire logic        [pcs_pkg::TYPE_W-1:0] in_type_mask_i,
  input  wire logic        [pcs_pkg::IDX_W-1:0]  in_self_index_i,
  output pcs_pkg::dp_status_t                   status_o,
  output logic                                  out_hit_o,
  output logic             [pcs_pkg::IDX_W-1:0]  out_hit_index_o
);

  localparam int AW = pcs_pkg::ADDR_W;
  localparam int PW = pcs_pkg::POS_W;
  localparam int DW = pcs_pkg::DIST_W;
  localparam int RW = pcs_pkg::RSUM_W;

  logic [pcs_pkg::FLAG_W-1:0] flag_mem [pcs_pkg::ENTRIES];
  logic [pcs_pkg::DATA_W-1:0] data_mem [pcs_pkg::ENTRIES];

  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] wr_addr;
  logic          flag_we;
  logic [pcs_pkg::FLAG_W-1:0] flag_wdata;

  // Probe
  logic signed [PW-1:0]             probe_x_q, probe_y_q;
  logic [pcs_pkg::RAD_W-1:0]        probe_r_q;
  logic [pcs_pkg::TYPE_W-1:0]       probe_mask_q;
  logic [pcs_pkg::IDX_W-1:0]        probe_self_q;

  // Stage 1: registered memory read
  logic                        s1_valid_q;
  logic [AW-1:0]               s1_addr_q;
  logic [pcs_pkg::FLAG_W-1:0]  s1_flags_q;
  logic [pcs_pkg::DATA_W-1:0]  s1_data_q;

  logic signed [PW-1:0] s1_ex, s1_ey;
  logic [pcs_pkg::RAD_W-1:0] s1_er;
  logic signed [PW:0] s1_diff_x, s1_diff_y;
  logic [PW:0]        s1_abs_x, s1_abs_y;
  logic               s1_qualify;

  // Stage 2: deltas and summed radius
  logic           s2_valid_q;
  logic [AW-1:0]  s2_addr_q;
  logic [DW-1:0]  s2_dx_q, s2_dy_q;
  logic [RW-1:0]  s2_r_q;

  // Stage 3: squares
  logic              s3_valid_q;
  logic [AW-1:0]     s3_addr_q;
  logic              s3_axis_ok_q;
  logic [2*DW-1:0]   s3_dxx_q, s3_dyy_q;
  logic [2*RW-1:0]   s3_rr_q;
  logic [2*DW:0]     s3_sum;
  logic              hit_found;

  logic                     res_hit_q;
  logic [pcs_pkg::IDX_W-1:0] res_idx_q;

  always_comb begin
    addr_d = addr_q;
    if (cmd_i.load) begin
      addr_d = AW'(in_index_i);
    end else if (cmd_i.clear || cmd_i.issue) begin
      addr_d = addr_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
    end else begin
      addr_q <= addr_d;
    end
  end

  // Write port: shared by the reset sweep and entry writes
  assign wr_addr    = cmd_i.clear ? addr_q : AW'(in_index_i);
  assign flag_we    = cmd_i.clear || cmd_i.write;
  assign flag_wdata = cmd_i.clear ? '0 : {in_type_bits_i, in_hit_enable_i, in_alive_i};

  always_ff @(posedge clk_i) begin
    if (flag_we) begin
      flag_mem[wr_addr] <= flag_wdata;
    end
    if (cmd_i.issue) begin
      s1_flags_q <= flag_mem[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      data_mem[wr_addr] <= {in_pos_x_i, in_pos_y_i, in_radius_i};
    end
    if (cmd_i.issue) begin
      s1_data_q <= data_mem[addr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      probe_x_q    <= in_pos_x_i;
      probe_y_q    <= in_pos_y_i;
      probe_r_q    <= in_radius_i;
      probe_mask_q <= in_type_mask_i;
      probe_self_q <= in_self_index_i;
    end
  end

  // Stage 1 compare: skip tests and absolute deltas
  always_comb begin
    s1_ex = s1_data_q[pcs_pkg::DATA_W-1 -: PW];
    s1_ey = s1_data_q[pcs_pkg::RAD_W +: PW];
    s1_er = s1_data_q[pcs_pkg::RAD_W-1:0];
    s1_diff_x = {s1_ex[PW-1], s1_ex} - {probe_x_q[PW-1], probe_x_q};
    s1_diff_y = {s1_ey[PW-1], s1_ey} - {probe_y_q[PW-1], probe_y_q};
    s1_abs_x  = s1_diff_x[PW] ? (~s1_diff_x + 1'b1) : s1_diff_x;
    s1_abs_y  = s1_diff_y[PW] ? (~s1_diff_y + 1'b1) : s1_diff_y;
    s1_qualify = s1_flags_q[pcs_pkg::FLAG_ALIVE]
              && s1_flags_q[pcs_pkg::FLAG_ENABLE]
              && ((s1_flags_q[pcs_pkg::FLAG_TYPE +: pcs_pkg::TYPE_W] & probe_mask_q) != '0)
              && (pcs_pkg::CNT_W'(s1_addr_q) != pcs_pkg::CNT_W'(probe_self_q));
  end

  always_ff @(posedge clk_i) begin
    s1_addr_q <= addr_q;
    s2_addr_q <= s1_addr_q;
    s2_dx_q   <= s1_abs_x[DW-1:0];
    s2_dy_q   <= s1_abs_y[DW-1:0];
    s2_r_q    <= RW'(s1_er) + RW'(probe_r_q);
    s3_addr_q    <= s2_addr_q;
    s3_axis_ok_q <= (s2_dx_q <= DW'(s2_r_q)) && (s2_dy_q <= DW'(s2_r_q));
    s3_dxx_q     <= s2_dx_q * s2_dx_q;
    s3_dyy_q     <= s2_dy_q * s2_dy_q;
    s3_rr_q      <= s2_r_q * s2_r_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.issue && !cmd_i.flush;
      s2_valid_q <= s1_valid_q && s1_qualify && !cmd_i.flush;
      s3_valid_q <= s2_valid_q && !cmd_i.flush;
    end
  end

  assign s3_sum    = (2*DW+1)'(s3_dxx_q) + (2*DW+1)'(s3_dyy_q);
  assign hit_found = s3_valid_q && s3_axis_ok_q && (s3_sum <= (2*DW+1)'(s3_rr_q));

  // Entries reach stage 3 in scan order, so the first hit seen is the answer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_hit_q <= 1'b0;
      res_idx_q <= '0;
    end else if (hit_found) begin
      res_hit_q <= 1'b1;
      res_idx_q <= pcs_pkg::IDX_W'(s3_addr_q);
    end
    if (cmd_i.out_load) begin
      out_hit_o       <= res_hit_q;
      out_hit_index_o <= res_idx_q;
    end
  end

  assign status_o.addr_last = (addr_q == AW'(pcs_pkg::ENTRIES - 1));
  assign status_o.hit_found = hit_found;
  assign status_o.pipe_busy = s1_valid_q || s2_valid_q || s3_valid_q;

endmodule
`default_nettype wire

### rtl/pcs_controller.sv
`default_nettype none
module pcs_controller (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic                               in_cmd_i,
  input  wire logic       [pcs_pkg::IDX_W-1:0]     in_index_i,
  input  wire logic       [pcs_pkg::SCAN_W-1:0]    in_scan_count_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output pcs_pkg::dp_cmd_t                        cmd_o,
  input  wire pcs_pkg::dp_status_t                status_i
);

  localparam int CW = pcs_pkg::CNT_W;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  logic [CW-1:0] rem_q, rem_d;
  logic          out_valid_q, out_valid_d;

  logic          accept;
  logic [CW-1:0] start;
  logic [CW-1:0] count;
  logic [CW-1:0] room;
  logic          in_range;
  logic [CW-1:0] span;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Entries to visit: scan count clipped at the table end
  assign start    = CW'(in_index_i);
  assign count    = CW'(in_scan_count_i);
  assign in_range = start < CW'(pcs_pkg::ENTRIES);
  assign room     = CW'(pcs_pkg::ENTRIES) - start;
  assign span     = !in_range ? '0 : ((count < room) ? count : room);

  always_comb begin
    state_d     = state_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.addr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          if (in_cmd_i == pcs_pkg::CMD_WRITE) begin
            cmd_o.write = in_range;
            state_d     = ST_FINISH;
          end else begin
            rem_d   = span;
            state_d = (span == '0) ? ST_FINISH : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (status_i.hit_found) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_FINISH;
        end else begin
          cmd_o.issue = 1'b1;
          rem_d       = rem_q - CW'(1);
          if (rem_q == CW'(1)) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (status_i.hit_found) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_FINISH;
        end else if (!status_i.pipe_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_hit_only_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.hit_found |-> (state_q == ST_SCAN) || (state_q == ST_DRAIN))
    else $error("collision reported outside a scan");

  a_scan_count_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (rem_q != '0))
    else $error("scan running with no entries left");

  a_result_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result presented without finishing a transaction");

  a_drain_no_issue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |=> !$past(cmd_o.issue))
    else $error("entry read issued while draining");

endmodule
`default_nettype wire
